// File: hw/rtl/rsr_pkg.sv
`default_nettype none

package rsr_pkg;

  // reservoir depth used when the top level is not overridden
  localparam int RESERVOIR_DEF = 6;

  localparam int RUN_W = 16;
  localparam logic [RUN_W-1:0] RUN_MAX = 16'hFFFF;

  // request modes
  localparam logic MODE_RECORD = 1'b0;
  localparam logic MODE_DRAIN  = 1'b1;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] key;
    logic        [31:0] payload_tag;
  } in_t;

  typedef struct packed {
    logic signed [31:0]      out_key;
    logic        [31:0]      out_tag;
    logic        [RUN_W-1:0] run_number;
    logic                    has_record;
    logic                    last;
  } out_t;

  // one reservoir entry as kept in the slot memory
  typedef struct packed {
    logic signed [31:0] key;
    logic        [31:0] tag;
  } slot_t;

endpackage

`default_nettype wire

// File: hw/rtl/rsr_slot_mem.sv
`default_nettype none

module rsr_slot_mem
  import rsr_pkg::*;
#(
  parameter  int DEPTH = RESERVOIR_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire slot_t         wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output slot_t              rd_data
);

  slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/replacement_selection_runs_unit.sv
`default_nettype none

// channel  direction  payload  handshake
// in_      input      in_t     in_valid / in_ready
// out_     output     out_t    out_valid / out_ready
//
// a record that only fills the reservoir is written straight to the slot memory;
// a record on a full reservoir runs the minimum scan, which reads one slot per
// cycle from the slot memory, then the emit step. a drain runs a scan and an
// emit step for each emitted record.
// rst_n is synchronous; after reset the reservoir is empty and run is zero.
// a stalled out_ready holds the emit step; a new request is taken while a
// finished result still waits in the output register.

module replacement_selection_runs_unit
  import rsr_pkg::*;
#(
  parameter int RESERVOIR = RESERVOIR_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  localparam int IDX_W = $clog2(RESERVOIR);
  localparam int CNT_W = $clog2(RESERVOIR + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RESERVOIR - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RESERVOIR);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // per-slot marks in flops, keys and tags in the slot memory
  logic [RESERVOIR-1:0] valid_r, valid_nxt;
  logic [RESERVOIR-1:0] frozen_r, frozen_nxt;
  logic [CNT_W-1:0]     fill_cnt_r, fill_cnt_nxt;
  logic [RUN_W-1:0]     run_r, run_nxt;
  logic                 drain_r, drain_nxt;

  // latched incoming record
  logic signed [31:0] key_r, key_nxt;
  logic [31:0]        tag_r, tag_nxt;

  // scan pipeline: read issue, compare in the cycle after the read
  logic [IDX_W-1:0] scan_addr_r, scan_addr_nxt;
  logic             scan_issue_r, scan_issue_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;

  // current minimum candidate
  logic               best_found_r, best_found_nxt;
  logic [IDX_W-1:0]   best_idx_r, best_idx_nxt;
  logic signed [31:0] best_key_r, best_key_nxt;
  logic [31:0]        best_tag_r, best_tag_nxt;

  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  // slot memory ports
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  slot_t            mem_wr_data;
  logic             mem_rd_en;
  slot_t            mem_rd_data;

  // marks after the emit step, before the new-run check
  logic [RESERVOIR-1:0] vld_w, frz_w;
  logic                 new_run;
  logic [RUN_W-1:0]     run_inc;
  logic                 cand;
  logic                 out_free;

  rsr_slot_mem #(
    .DEPTH (RESERVOIR)
  ) u_slot_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (scan_addr_r),
    .rd_data (mem_rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign out_free = !out_valid_r || out_ready;
  assign run_inc  = (run_r == RUN_MAX) ? run_r : run_r + RUN_W'(1);
  assign cand     = valid_r[cmp_idx_r] && !frozen_r[cmp_idx_r];

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    frozen_nxt     = frozen_r;
    fill_cnt_nxt   = fill_cnt_r;
    run_nxt        = run_r;
    drain_nxt      = drain_r;
    key_nxt        = key_r;
    tag_nxt        = tag_r;
    scan_addr_nxt  = scan_addr_r;
    scan_issue_nxt = scan_issue_r;
    cmp_vld_nxt    = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_key_nxt   = best_key_r;
    best_tag_nxt   = best_tag_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = best_idx_r;
    mem_wr_data    = '{key: key_r, tag: tag_r};
    mem_rd_en      = 1'b0;
    vld_w          = valid_r;
    frz_w          = frozen_r;
    new_run        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt = in_data.key;
          tag_nxt = in_data.payload_tag;
          if (in_data.mode == MODE_RECORD && fill_cnt_r != FULL_CNT) begin
            // fill phase: lowest empty slot is the fill count
            mem_wr_en   = 1'b1;
            mem_wr_addr = fill_cnt_r[IDX_W-1:0];
            mem_wr_data = '{key: in_data.key, tag: in_data.payload_tag};
            valid_nxt[fill_cnt_r[IDX_W-1:0]]  = 1'b1;
            frozen_nxt[fill_cnt_r[IDX_W-1:0]] = 1'b0;
            fill_cnt_nxt = fill_cnt_r + CNT_W'(1);
          end else begin
            drain_nxt      = (in_data.mode == MODE_DRAIN);
            scan_addr_nxt  = '0;
            scan_issue_nxt = 1'b1;
            best_found_nxt = 1'b0;
            state_nxt      = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (scan_issue_r) begin
          mem_rd_en   = 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = scan_addr_r;
          if (scan_addr_r == LAST_IDX) begin
            scan_issue_nxt = 1'b0;
          end else begin
            scan_addr_nxt = scan_addr_r + IDX_W'(1);
          end
        end
        if (cmp_vld_r) begin
          // strict less keeps the lowest slot on equal keys
          if (cand && (!best_found_r || $signed(mem_rd_data.key) < best_key_r)) begin
            best_found_nxt = 1'b1;
            best_idx_nxt   = cmp_idx_r;
            best_key_nxt   = mem_rd_data.key;
            best_tag_nxt   = mem_rd_data.tag;
          end
          if (cmp_idx_r == LAST_IDX) begin
            state_nxt = S_EMIT;
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (!best_found_r) begin
            // empty drain marker, then back to reset state
            out_data_nxt = '{out_key: '0, out_tag: '0, run_number: run_r,
                             has_record: 1'b0, last: 1'b1};
            valid_nxt    = '0;
            frozen_nxt   = '0;
            fill_cnt_nxt = '0;
            run_nxt      = '0;
            state_nxt    = S_IDLE;
          end else if (!drain_r) begin
            out_data_nxt = '{out_key: best_key_r, out_tag: best_tag_r,
                             run_number: run_r, has_record: 1'b1, last: 1'b0};
            // refill the emitted slot, frozen if it falls below the output
            mem_wr_en         = 1'b1;
            frz_w[best_idx_r] = (key_r < best_key_r);
            // a new run opens when valid slots remain and every one of them is frozen
            new_run = (|vld_w) && ((vld_w & ~frz_w) == '0);
            if (new_run) begin
              frozen_nxt = '0;
              run_nxt    = run_inc;
            end else begin
              frozen_nxt = frz_w;
            end
            state_nxt = S_IDLE;
          end else begin
            vld_w[best_idx_r] = 1'b0;
            frz_w[best_idx_r] = 1'b0;
            new_run = (|vld_w) && ((vld_w & ~frz_w) == '0);
            out_data_nxt = '{out_key: best_key_r, out_tag: best_tag_r,
                             run_number: run_r, has_record: 1'b1,
                             last: (vld_w == '0)};
            if (vld_w == '0) begin
              valid_nxt    = '0;
              frozen_nxt   = '0;
              fill_cnt_nxt = '0;
              run_nxt      = '0;
              state_nxt    = S_IDLE;
            end else begin
              valid_nxt = vld_w;
              if (new_run) begin
                frozen_nxt = '0;
                run_nxt    = run_inc;
              end else begin
                frozen_nxt = frz_w;
              end
              // next drain step
              scan_addr_nxt  = '0;
              scan_issue_nxt = 1'b1;
              best_found_nxt = 1'b0;
              state_nxt      = S_SCAN;
            end
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      frozen_r     <= '0;
      fill_cnt_r   <= '0;
      run_r        <= '0;
      drain_r      <= 1'b0;
      scan_issue_r <= 1'b0;
      cmp_vld_r    <= 1'b0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      frozen_r     <= frozen_nxt;
      fill_cnt_r   <= fill_cnt_nxt;
      run_r        <= run_nxt;
      drain_r      <= drain_nxt;
      scan_issue_r <= scan_issue_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      best_found_r <= best_found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    tag_r       <= tag_nxt;
    scan_addr_r <= scan_addr_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_key_r  <= best_key_nxt;
    best_tag_r  <= best_tag_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

`default_nettype wire

// File: tb/replacement_selection_runs_unit_test.sv
`default_nettype none

module replacement_selection_runs_unit_test;
  import rsr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RES = RESERVOIR_DEF;
  // tail wait after the last phase, sized from the reservoir depth
  localparam int TAIL_CYCLES = 4 * (RES + 3);
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

  // how keys of one random sequence are shaped
  typedef enum int {
    KS_UNIFORM,
    KS_CLUSTER,
    KS_RISING,
    KS_FALLING,
    KS_EXTREME
  } key_style_e;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  replacement_selection_runs_unit #(
    .RESERVOIR(RES)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // requests waiting for the driver, and emitted records still to come
  in_t  requests_to_send[$];
  out_t emits_due[$];

  // shadow reservoir kept by the predictor
  logic signed [31:0] shadow_key[RES];
  logic        [31:0] shadow_tag[RES];
  bit                 shadow_valid[RES];
  bit                 shadow_frozen[RES];
  logic [RUN_W-1:0]   shadow_run;

  // idling knobs, changed per phase by the stimulus process
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  offer_live = 1'b0;
  bit  hold_arm = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;
  bit  failed = 1'b0;
  int  cycle_count = 0;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  task automatic clear_shadow();
    for (int i = 0; i < RES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_frozen[i] = 1'b0;
    end
    shadow_run = '0;
  endtask

  // smallest unfrozen key, lowest slot on ties; -1 when nothing is open
  function automatic int open_min_slot();
    int best;
    best = -1;
    for (int i = 0; i < RES; i++) begin
      if (shadow_valid[i] && !shadow_frozen[i]) begin
        if (best < 0 || shadow_key[i] < shadow_key[best]) best = i;
      end
    end
    return best;
  endfunction

  // once every occupied slot is frozen the next run opens
  task automatic roll_run_if_frozen();
    bit any_valid;
    bit any_open;
    any_valid = 1'b0;
    any_open = 1'b0;
    for (int i = 0; i < RES; i++) begin
      if (shadow_valid[i]) begin
        any_valid = 1'b1;
        if (!shadow_frozen[i]) any_open = 1'b1;
      end
    end
    if (any_valid && !any_open) begin
      for (int i = 0; i < RES; i++) shadow_frozen[i] = 1'b0;
      if (shadow_run != RUN_MAX) shadow_run = shadow_run + RUN_W'(1);
    end
  endtask

  task automatic predict_emits(input in_t req);
    int   idx;
    int   count;
    bit   filled;
    bit   held;
    out_t emit;
    out_t prev;
    filled = 1'b0;
    held = 1'b0;
    count = 0;
    prev = '0;
    if (req.mode == MODE_RECORD) begin
      // fill phase: the lowest empty slot takes the record, nothing comes out
      for (int i = 0; i < RES; i++) begin
        if (!filled && !shadow_valid[i]) begin
          shadow_key[i] = req.key;
          shadow_tag[i] = req.payload_tag;
          shadow_valid[i] = 1'b1;
          shadow_frozen[i] = 1'b0;
          filled = 1'b1;
        end
      end
      if (!filled) begin
        roll_run_if_frozen();
        idx = open_min_slot();
        if (idx >= 0) begin
          emit.out_key = shadow_key[idx];
          emit.out_tag = shadow_tag[idx];
          emit.run_number = shadow_run;
          emit.has_record = 1'b1;
          emit.last = 1'b0;
          emits_due.push_back(emit);
          // a key below the one just emitted waits for the next run
          shadow_frozen[idx] = (req.key < shadow_key[idx]);
          shadow_key[idx] = req.key;
          shadow_tag[idx] = req.payload_tag;
          roll_run_if_frozen();
        end
      end
    end else begin
      // drain: emit in selection order, the final one carries last
      idx = 0;
      while (count < RES && idx >= 0) begin
        roll_run_if_frozen();
        idx = open_min_slot();
        if (idx >= 0) begin
          if (held) emits_due.push_back(prev);
          prev.out_key = shadow_key[idx];
          prev.out_tag = shadow_tag[idx];
          prev.run_number = shadow_run;
          prev.has_record = 1'b1;
          prev.last = 1'b0;
          held = 1'b1;
          shadow_valid[idx] = 1'b0;
          shadow_frozen[idx] = 1'b0;
          count++;
        end
      end
      if (held) begin
        prev.last = 1'b1;
        emits_due.push_back(prev);
      end else begin
        // empty reservoir gives a bare marker
        emit.out_key = '0;
        emit.out_tag = '0;
        emit.run_number = shadow_run;
        emit.has_record = 1'b0;
        emit.last = 1'b1;
        emits_due.push_back(emit);
      end
      clear_shadow();
    end
  endtask

  task automatic check_emit(input out_t got, input out_t want);
    if (got.out_key !== want.out_key) begin
      $error("out_key mismatch: expected %0d, got %0d", want.out_key, got.out_key);
      failed = 1'b1;
    end
    if (got.out_tag !== want.out_tag) begin
      $error("out_tag mismatch: expected %h, got %h", want.out_tag, got.out_tag);
      failed = 1'b1;
    end
    if (got.run_number !== want.run_number) begin
      $error("run_number mismatch: expected %0d, got %0d", want.run_number, got.run_number);
      failed = 1'b1;
    end
    if (got.has_record !== want.has_record) begin
      $error("has_record mismatch: expected %b, got %b", want.has_record, got.has_record);
      failed = 1'b1;
    end
    if (got.last !== want.last) begin
      $error("last mismatch: expected %b, got %b", want.last, got.last);
      failed = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers the next request at the falling edge, holds it until taken
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!offer_live) begin
      if (requests_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data <= requests_to_send.pop_front();
        in_valid <= 1'b1;
        offer_live = 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off counted here
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_arm && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: handshakes sampled at the rising edge, plus the cycle limit
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else if (rst_n) begin
      if (out_valid && out_ready) begin
        if (emits_due.size() == 0) begin
          $error("unexpected result: key %0d tag %h run %0d", out_data.out_key,
                 out_data.out_tag, out_data.run_number);
          failed = 1'b1;
        end else begin
          check_emit(out_data, emits_due.pop_front());
        end
      end
      // predict before releasing the offer so the stimulus never sees a gap
      if (in_valid && in_ready) begin
        predict_emits(in_data);
        offer_live = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic push_record(input logic signed [31:0] key, input logic [31:0] tag);
    in_t req;
    req.mode = MODE_RECORD;
    req.key = key;
    req.payload_tag = tag;
    requests_to_send.push_back(req);
  endtask

  // key and tag of a drain are don't-care, so they get noise
  task automatic push_drain();
    in_t req;
    req.mode = MODE_DRAIN;
    req.key = $urandom;
    req.payload_tag = $urandom;
    requests_to_send.push_back(req);
  endtask

  function automatic logic signed [31:0] pick_key(input key_style_e style, input int pos);
    int k;
    case (style)
      KS_UNIFORM: begin
        k = $urandom;
      end
      KS_CLUSTER: begin
        // heavy ties exercise the lowest-slot rule
        k = int'($urandom_range(0, 8)) - 4;
      end
      KS_RISING: begin
        k = pos * 1000 + int'($urandom_range(0, 2999)) - 50000;
      end
      KS_FALLING: begin
        k = 50000 - pos * 1000 + int'($urandom_range(0, 2999));
      end
      default: begin
        case ($urandom_range(0, 3))
          0: k = KEY_MIN;
          1: k = KEY_MAX;
          2: k = 0;
          default: k = -1;
        endcase
      end
    endcase
    return k;
  endfunction

  // mostly full sequences that pass the fill phase, some short ones and stray drains
  task automatic queue_random_requests(input int total);
    int         left;
    int         len;
    key_style_e style;
    left = total;
    while (left > 0) begin
      style = key_style_e'($urandom_range(0, 4));
      if ($urandom_range(0, 99) < 15) len = $urandom_range(0, 5);
      else len = $urandom_range(6, 30);
      for (int i = 0; i < len && left > 0; i++) begin
        if ($urandom_range(0, 99) < 3) push_drain();
        else push_record(pick_key(style, i), $urandom);
        left--;
      end
      // sometimes the reservoir carries over into the next sequence
      if ($urandom_range(0, 99) < 80) begin
        push_drain();
        left--;
      end
    end
  endtask

  task automatic wait_settled();
    while (requests_to_send.size() != 0 || offer_live || emits_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int stall_pct, input int total);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    queue_random_requests(total);
    wait_settled();
  endtask

  initial begin
    clear_shadow();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty drain, extreme keys with a tie, forced run change
    push_drain();
    push_record(KEY_MAX, 32'h0000_0000);
    push_record(KEY_MIN, 32'hFFFF_FFFF);
    push_record(0, 32'hAAAA_5555);
    push_record(-1, 32'h5555_AAAA);
    push_record(1, 32'h0000_0001);
    push_record(0, 32'h8000_0000);
    // falling keys freeze one slot after another until the run turns over
    for (int i = 1; i <= 7; i++) push_record(-100 * i, $urandom);
    // smallest key freezes again, so the drain itself crosses a run boundary
    push_record(KEY_MIN, 32'h1234_5678);
    push_drain();
    // partial reservoir drain, then a drain right after a drain
    push_record(7, $urandom);
    push_record(KEY_MAX, $urandom);
    push_drain();
    push_drain();
    wait_settled();

    run_phase(0, 0, 60);
    run_phase(75, 0, 50);
    run_phase(0, 75, 50);
    run_phase(27, 27, 50);

    // back-pressure: receiver holds off while requests keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 40; i++) push_record(pick_key(KS_UNIFORM, i), $urandom);
    push_drain();
    hold_arm = 1'b1;
    wait_settled();

    // let any fill-only request finish, any stray result would be flagged
    repeat (TAIL_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
